[design/bitplane_lcd_controller_defines.svh]
// Assertion macros for the LCD controller top level.
`ifndef BITPLANE_LCD_CONTROLLER_DEFINES_SVH
`define BITPLANE_LCD_CONTROLLER_DEFINES_SVH
`ifndef SYNTH
`define BLC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define BLC_ASSERT_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);
`else
`define BLC_ASSERT(label, prop, msg)
`define BLC_ASSERT_NEVER(label, expr, msg)
`endif
`endif

[design/blc_pkg.sv]
package blc_pkg;

   // operation codes (req_tuser)
   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_PIXEL = 2'd2;
   localparam logic [1:0] OP_TICK  = 2'd3;

   // register addresses
   localparam logic [2:0] REG_MODE     = 3'd1;
   localparam logic [2:0] REG_SCROLL_X = 3'd2;
   localparam logic [2:0] REG_SCROLL_Y = 3'd3;
   localparam logic [2:0] REG_PTR_LO   = 3'd4;
   localparam logic [2:0] REG_PTR_HI   = 3'd5;
   localparam logic [2:0] REG_DATA_RD  = 3'd6;
   localparam logic [2:0] REG_DATA_WR  = 3'd7;

   localparam int PLANE_DEPTH = 8192;
   localparam int PLANE_AW    = 13;
   localparam int BYTE_W      = 8;
   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 40;
   localparam int RSP_PAD_W   = 5;

   localparam logic [PLANE_AW-1:0] PTR_STEP_ONE = 13'd1;
   localparam logic [PLANE_AW-1:0] PTR_STEP_ROW = 13'd32;

   localparam logic [8:0] ROW_MODULO    = 9'd200;
   localparam logic [8:0] ROW_MODULO_X2 = 9'd400;
   localparam logic [7:0] WINDOW_ROWS     = 8'd16;
   localparam logic [7:0] WINDOW_ROW_BASE = 8'hD0;

   localparam logic [15:0] IRQ_PERIOD_RESET = 16'd16384;
   localparam logic [4:0]  MOD_LAST_STEP    = 5'd16;
   localparam logic [7:0]  READ_IDLE_BYTE   = 8'hFF;

   typedef struct packed {
      logic accept;
      logic clear_active;
      logic mem_load;
      logic mod_active;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_free;
      logic needs_clear;
      logic needs_mem;
      logic needs_mod;
      logic clear_last;
      logic mod_last;
   } dp_status_type;

   // fixed palette, {red, green, blue}
   function automatic logic [23:0] palette_rgb(input logic [1:0] shade);
      logic [23:0] rgb;
      unique case (shade)
         2'd0: rgb = {8'd127, 8'd134, 8'd15};
         2'd1: rgb = {8'd87, 8'd124, 8'd68};
         2'd2: rgb = {8'd54, 8'd93, 8'd72};
         default: rgb = {8'd42, 8'd69, 8'd59};
      endcase
      return rgb;
   endfunction

endpackage

[design/blc_ram.sv]
module blc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/blc_ctrl.sv]
module blc_ctrl
   import blc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  dp_status_type sts,
   output ctrl_cmd_type  cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_CLEAR = 2'd1;
   localparam logic [1:0] ST_MEM   = 2'd2;
   localparam logic [1:0] ST_MOD   = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       accept;

   assign req_tready = (state_ff == ST_IDLE) && sts.out_free;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               priority if (sts.needs_clear) state_in = ST_CLEAR;
               else if (sts.needs_mem)       state_in = ST_MEM;
               else if (sts.needs_mod)       state_in = ST_MOD;
               else                          state_in = ST_IDLE;
            end
         end
         ST_CLEAR: begin
            if (sts.clear_last) state_in = ST_IDLE;
         end
         ST_MEM: begin
            state_in = ST_IDLE;
         end
         default: begin
            if (sts.mod_last) state_in = ST_IDLE;
         end
      endcase
   end

   // both planes are swept after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign cmd.accept       = accept;
   assign cmd.clear_active = (state_ff == ST_CLEAR);
   assign cmd.mem_load     = (state_ff == ST_MEM);
   assign cmd.mod_active   = (state_ff == ST_MOD);

endmodule

[design/blc_datapath.sv]
module blc_datapath
   import blc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic [1:0]             req_tuser,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic                   csr_we,
   input  logic [15:0]            csr_wdata,
   input  ctrl_cmd_type           cmd,
   output dp_status_type          sts
);

   logic [1:0] op;
   logic [2:0] reg_addr;
   logic [7:0] wdata;
   logic [7:0] sx;
   logic [7:0] sy;

   assign op       = req_tuser;
   assign reg_addr = req_tdata[2:0];
   assign wdata    = req_tdata[10:3];
   assign sx       = req_tdata[18:11];
   assign sy       = req_tdata[26:19];

   // architectural state
   logic [13:0] ptr_ff, ptr_in;
   logic        step_row_ff, step_row_in;
   logic        swap_ff, swap_in;
   logic        window_ff, window_in;
   logic [7:0]  scroll_x_ff, scroll_x_in;
   logic [7:0]  scroll_y_ff, scroll_y_in;
   logic [15:0] tick_ff, tick_in;
   logic [15:0] period_ff, period_in;

   // sequencing
   logic [PLANE_AW-1:0] clr_cnt_ff, clr_cnt_in;
   logic [4:0]          mod_cnt_ff, mod_cnt_in;
   logic [16:0]         div_ff, div_in;
   logic [15:0]         rem_ff, rem_in;
   logic                pend_pixel_ff, pend_pixel_in;
   logic                pend_high_ff, pend_high_in;
   logic [2:0]          pend_bit_ff, pend_bit_in;

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rd_data_ff, rd_data_in;
   logic [1:0] shade_ff, shade_in;
   logic [7:0] red_ff, red_in;
   logic [7:0] green_ff, green_in;
   logic [7:0] blue_ff, blue_in;
   logic       irq_ff, irq_in;

   // pixel address
   logic [8:0]          y_sum;
   logic [8:0]          y_wrap;
   logic                in_window;
   logic [7:0]          pix_row;
   logic [7:0]          pix_col;
   logic [PLANE_AW-1:0] pix_idx;

   assign y_sum = {1'b0, sy} + {1'b0, scroll_y_ff};

   // sum is below three times the row count
   always_comb begin
      priority if (y_sum >= ROW_MODULO_X2) y_wrap = y_sum - ROW_MODULO_X2;
      else if (y_sum >= ROW_MODULO)         y_wrap = y_sum - ROW_MODULO;
      else                                  y_wrap = y_sum;
   end

   assign in_window = window_ff && (sy < WINDOW_ROWS);
   assign pix_row   = in_window ? (WINDOW_ROW_BASE + sy) : y_wrap[7:0];
   assign pix_col   = in_window ? sx : (sx + scroll_x_ff);
   assign pix_idx   = {pix_row, pix_col[7:3]};

   // pointer step, plane bit kept
   logic [13:0] ptr_stepped;
   assign ptr_stepped = {ptr_ff[13],
                         ptr_ff[12:0] + (step_row_ff ? PTR_STEP_ROW : PTR_STEP_ONE)};

   // timer
   logic [16:0] tick_next;
   logic [16:0] period_ext;
   logic [16:0] tick_diff;
   logic        period_zero;
   logic        tick_wrap;
   logic        tick_slow;

   assign tick_next   = {1'b0, tick_ff} + 17'd1;
   assign period_ext  = {1'b0, period_ff};
   assign tick_diff   = tick_next - period_ext;
   assign period_zero = (period_ff == 16'd0);
   assign tick_wrap   = !period_zero && (tick_next >= period_ext);
   assign tick_slow   = tick_wrap && (tick_diff >= period_ext);

   // one restoring remainder step per cycle
   logic [16:0] mod_trial;
   logic [16:0] mod_sub;
   logic [15:0] mod_rem;

   assign mod_trial = {rem_ff, div_ff[16]};
   assign mod_sub   = mod_trial - period_ext;
   assign mod_rem   = (mod_trial >= period_ext) ? mod_sub[15:0] : mod_trial[15:0];

   // decode
   logic is_data_rd;
   logic is_data_wr;

   assign is_data_rd = (op == OP_READ) && (reg_addr == REG_DATA_RD);
   assign is_data_wr = (op == OP_WRITE) && (reg_addr == REG_DATA_WR);

   assign sts.out_free    = !rsp_valid_ff || rsp_tready;
   assign sts.needs_clear = (op == OP_WRITE) && (reg_addr == REG_MODE) && wdata[7];
   assign sts.needs_mem   = (op == OP_PIXEL) || is_data_rd;
   assign sts.needs_mod   = (op == OP_TICK) && tick_slow;
   assign sts.clear_last  = (clr_cnt_ff == {PLANE_AW{1'b1}});
   assign sts.mod_last    = (mod_cnt_ff == MOD_LAST_STEP);

   // plane memories
   logic                wr_lo;
   logic                wr_hi;
   logic [PLANE_AW-1:0] wr_addr;
   logic [7:0]          wr_byte;
   logic [PLANE_AW-1:0] rd_addr;
   logic [7:0]          lo_q;
   logic [7:0]          hi_q;

   assign wr_lo   = cmd.clear_active || (cmd.accept && is_data_wr && !ptr_ff[13]);
   assign wr_hi   = cmd.clear_active || (cmd.accept && is_data_wr && ptr_ff[13]);
   assign wr_addr = cmd.clear_active ? clr_cnt_ff : ptr_ff[12:0];
   assign wr_byte = cmd.clear_active ? 8'd0 : wdata;
   assign rd_addr = (op == OP_PIXEL) ? pix_idx : ptr_ff[12:0];

   blc_ram #(.WIDTH(BYTE_W), .DEPTH(PLANE_DEPTH)) u_plane_lo (
      .clock   (clock),
      .wr_en   (wr_lo),
      .wr_addr (wr_addr),
      .wr_data (wr_byte),
      .rd_addr (rd_addr),
      .rd_data (lo_q)
   );

   blc_ram #(.WIDTH(BYTE_W), .DEPTH(PLANE_DEPTH)) u_plane_hi (
      .clock   (clock),
      .wr_en   (wr_hi),
      .wr_addr (wr_addr),
      .wr_data (wr_byte),
      .rd_addr (rd_addr),
      .rd_data (hi_q)
   );

   // deferred result from the memory read
   logic       b_lo;
   logic       b_hi;
   logic [1:0] mem_shade;
   logic [23:0] mem_rgb;

   assign b_lo      = lo_q[~pend_bit_ff];
   assign b_hi      = hi_q[~pend_bit_ff];
   assign mem_shade = swap_ff ? {b_lo, b_hi} : {b_hi, b_lo};
   assign mem_rgb   = palette_rgb(mem_shade);

   logic load_now;
   assign load_now = cmd.accept && !sts.needs_mem;

   always_comb begin
      ptr_in        = ptr_ff;
      step_row_in   = step_row_ff;
      swap_in       = swap_ff;
      window_in     = window_ff;
      scroll_x_in   = scroll_x_ff;
      scroll_y_in   = scroll_y_ff;
      tick_in       = tick_ff;
      period_in     = csr_we ? csr_wdata : period_ff;
      clr_cnt_in    = cmd.clear_active ? clr_cnt_ff + PTR_STEP_ONE : clr_cnt_ff;
      mod_cnt_in    = mod_cnt_ff;
      div_in        = div_ff;
      rem_in        = rem_ff;
      pend_pixel_in = pend_pixel_ff;
      pend_high_in  = pend_high_ff;
      pend_bit_in   = pend_bit_ff;
      rsp_valid_in  = rsp_tready ? 1'b0 : rsp_valid_ff;
      rd_data_in    = rd_data_ff;
      shade_in      = shade_ff;
      red_in        = red_ff;
      green_in      = green_ff;
      blue_in       = blue_ff;
      irq_in        = irq_ff;

      if (cmd.accept) begin
         pend_pixel_in = (op == OP_PIXEL);
         pend_high_in  = ptr_ff[13];
         pend_bit_in   = pix_col[2:0];
         unique case (op)
            OP_WRITE: begin
               unique case (reg_addr)
                  REG_MODE: begin
                     swap_in     = wdata[4];
                     window_in   = wdata[5];
                     step_row_in = wdata[6];
                  end
                  REG_SCROLL_X: scroll_x_in = wdata;
                  REG_SCROLL_Y: scroll_y_in = wdata;
                  REG_PTR_LO:   ptr_in = {wdata[7], ptr_ff[12:5], wdata[4:0]};
                  REG_PTR_HI:   ptr_in = {ptr_ff[13], wdata, ptr_ff[4:0]};
                  REG_DATA_WR:  ptr_in = ptr_stepped;
                  default: ;
               endcase
            end
            OP_READ: begin
               if (is_data_rd) ptr_in = ptr_stepped;
            end
            OP_TICK: begin
               priority if (period_zero) tick_in = 16'd0;
               else if (tick_slow) begin
                  div_in     = tick_next;
                  rem_in     = 16'd0;
                  mod_cnt_in = 5'd0;
               end
               else if (tick_wrap) tick_in = tick_diff[15:0];
               else                tick_in = tick_next[15:0];
            end
            default: ;
         endcase
      end

      if (cmd.mod_active) begin
         div_in     = {div_ff[15:0], 1'b0};
         rem_in     = mod_rem;
         mod_cnt_in = sts.mod_last ? 5'd0 : mod_cnt_ff + 5'd1;
         if (sts.mod_last) tick_in = mod_rem;
      end

      if (load_now) begin
         rsp_valid_in = 1'b1;
         rd_data_in   = READ_IDLE_BYTE;
         shade_in     = 2'd0;
         red_in       = 8'd0;
         green_in     = 8'd0;
         blue_in      = 8'd0;
         irq_in       = (op == OP_TICK) && (period_zero || tick_wrap);
      end else if (cmd.mem_load) begin
         rsp_valid_in = 1'b1;
         irq_in       = 1'b0;
         if (pend_pixel_ff) begin
            rd_data_in = READ_IDLE_BYTE;
            shade_in   = mem_shade;
            red_in     = mem_rgb[23:16];
            green_in   = mem_rgb[15:8];
            blue_in    = mem_rgb[7:0];
         end else begin
            rd_data_in = pend_high_ff ? hi_q : lo_q;
            shade_in   = 2'd0;
            red_in     = 8'd0;
            green_in   = 8'd0;
            blue_in    = 8'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff       <= 14'd0;
         step_row_ff  <= 1'b0;
         swap_ff      <= 1'b0;
         window_ff    <= 1'b0;
         scroll_x_ff  <= 8'd0;
         scroll_y_ff  <= 8'd0;
         tick_ff      <= 16'd0;
         period_ff    <= IRQ_PERIOD_RESET;
         clr_cnt_ff   <= '0;
         mod_cnt_ff   <= 5'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ptr_ff       <= ptr_in;
         step_row_ff  <= step_row_in;
         swap_ff      <= swap_in;
         window_ff    <= window_in;
         scroll_x_ff  <= scroll_x_in;
         scroll_y_ff  <= scroll_y_in;
         tick_ff      <= tick_in;
         period_ff    <= period_in;
         clr_cnt_ff   <= clr_cnt_in;
         mod_cnt_ff   <= mod_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      div_ff        <= div_in;
      rem_ff        <= rem_in;
      pend_pixel_ff <= pend_pixel_in;
      pend_high_ff  <= pend_high_in;
      pend_bit_ff   <= pend_bit_in;
      rd_data_ff    <= rd_data_in;
      shade_ff      <= shade_in;
      red_ff        <= red_in;
      green_ff      <= green_in;
      blue_ff       <= blue_in;
      irq_ff        <= irq_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, irq_ff, blue_ff, green_ff, red_ff,
                        shade_ff, rd_data_ff};

endmodule

[design/bitplane_lcd_controller.sv]
// Bitplane LCD controller.
// req_* carries one command word: tuser selects register write, register
// read, pixel fetch or timer tick; tdata carries address, data and the
// screen position. rsp_* returns exactly one result word per command.
// csr_we/csr_wdata load the interrupt period; write it only while idle.
// Writes, ticks and reads of addresses other than 6 answer in the cycle after
// acceptance; data reads and pixel fetches pass first through the plane
// memories' registered read port and then through the result register.
// Writes and ticks are taken one word per cycle while rsp_tready is high; a
// memory read ends before the next command is taken, and a tick whose count
// needs a true remainder first runs the shift-subtract unit.
// After reset, and after a mode write with bit 7 set, both planes are
// swept to zero one address per cycle over all 8192 addresses, while req_tready
// stays low; csr writes are still taken.
// The result register holds a word while rsp_tready is low; a new command
// is taken only once that register is free or being drained.
`include "bitplane_lcd_controller_defines.svh"

module bitplane_lcd_controller
   import blc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // reg_addr[2:0], write_data[10:3], screen_x[18:11], screen_y[26:19]
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // operation[1:0]
   input  logic [1:0]             req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // read_data[7:0], shade[9:8], red[17:10], green[25:18], blue[33:26],
   // irq_request[34]
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_we,
   input  logic [15:0]            csr_wdata
);

   ctrl_cmd_type  cmd;
   dp_status_type sts;

   blc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   blc_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .sts        (sts)
   );

   `BLC_ASSERT(a_no_overwrite, (req_tvalid && req_tready) |-> (!rsp_tvalid || rsp_tready), "word accepted while result register blocked")
   `BLC_ASSERT(a_mem_load_origin, cmd.mem_load |-> ($past(cmd.accept && sts.needs_mem) && !rsp_tvalid), "memory result without a pending read")
   `BLC_ASSERT_NEVER(a_clear_blocks, cmd.clear_active && req_tready, "command taken during plane sweep")

endmodule

[tb/tb_bitplane_lcd_controller.sv]
`timescale 1ns / 1ps

module tb_bitplane_lcd_controller;
   import blc_pkg::*;

   localparam logic [2:0] REG_UNUSED = 3'd0;
   localparam int LIMIT_CYCLES = 1_000_000;
   localparam int RANDOM_ITEMS = 1925;
   localparam int HOLD_AT = 600;
   localparam int HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES = 40;

   typedef struct packed {
      logic       irq;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
      logic [1:0] shade;
      logic [7:0] rd;
   } lcd_word_type;

   // Shadow copy of the controller: video memory, pointer, modes and timer.
   class lcd_shadow_type;
      bit [7:0]  plane_lo [PLANE_DEPTH];
      bit [7:0]  plane_hi [PLANE_DEPTH];
      bit [13:0] ptr;
      bit        step_by_row;
      bit        swap;
      bit        window;
      bit [7:0]  scroll_x;
      bit [7:0]  scroll_y;
      bit [15:0] tick_count;
      bit [15:0] irq_period;
      lcd_word_type owed [$];
      int        faults;

      function new();
         wipe_planes();
         ptr = '0;
         step_by_row = 1'b0;
         swap = 1'b0;
         window = 1'b0;
         scroll_x = '0;
         scroll_y = '0;
         tick_count = '0;
         irq_period = IRQ_PERIOD_RESET;
         faults = 0;
      endfunction

      function void wipe_planes();
         foreach (plane_lo[i]) begin
            plane_lo[i] = '0;
            plane_hi[i] = '0;
         end
      endfunction

      // plane bit is kept, the byte address wraps in 13 bits
      function void advance_ptr();
         ptr[12:0] = ptr[12:0] + (step_by_row ? PTR_STEP_ROW : PTR_STEP_ONE);
      endfunction

      function void take_command(bit [1:0] op, bit [2:0] addr, bit [7:0] data,
                                 bit [7:0] x, bit [7:0] y);
         lcd_word_type w;
         bit [8:0]    row;
         bit [7:0]    col;
         bit [12:0]   idx;
         bit          lo_bit;
         bit          hi_bit;
         int unsigned nxt;
         w = '0;
         w.rd = READ_IDLE_BYTE;
         case (op)
            OP_WRITE: begin
               case (addr)
                  REG_MODE: begin
                     swap = data[4];
                     window = data[5];
                     step_by_row = data[6];
                     if (data[7]) wipe_planes();
                  end
                  REG_SCROLL_X: scroll_x = data;
                  REG_SCROLL_Y: scroll_y = data;
                  REG_PTR_LO: ptr = {data[7], ptr[12:5], data[4:0]};
                  REG_PTR_HI: ptr = {ptr[13], data, ptr[4:0]};
                  REG_DATA_WR: begin
                     if (ptr[13]) plane_hi[ptr[12:0]] = data;
                     else plane_lo[ptr[12:0]] = data;
                     advance_ptr();
                  end
                  default: ;
               endcase
            end
            OP_READ: begin
               if (addr == REG_DATA_RD) begin
                  w.rd = ptr[13] ? plane_hi[ptr[12:0]] : plane_lo[ptr[12:0]];
                  advance_ptr();
               end
            end
            OP_PIXEL: begin
               if (window && y < WINDOW_ROWS) begin
                  row = 9'(y) + 9'(WINDOW_ROW_BASE);
                  col = x;
               end else begin
                  row = (9'(y) + 9'(scroll_y)) % ROW_MODULO;
                  col = x + scroll_x;
               end
               idx = {row[7:0], col[7:3]};
               // leftmost pixel sits in bit 7
               lo_bit = plane_lo[idx][~col[2:0]];
               hi_bit = plane_hi[idx][~col[2:0]];
               w.shade = swap ? {lo_bit, hi_bit} : {hi_bit, lo_bit};
               case (w.shade)
                  2'd0: {w.red, w.green, w.blue} = {8'd127, 8'd134, 8'd15};
                  2'd1: {w.red, w.green, w.blue} = {8'd87, 8'd124, 8'd68};
                  2'd2: {w.red, w.green, w.blue} = {8'd54, 8'd93, 8'd72};
                  default: {w.red, w.green, w.blue} = {8'd42, 8'd69, 8'd59};
               endcase
            end
            default: begin
               nxt = tick_count + 1;
               if (irq_period == 0) begin
                  w.irq = 1'b1;
                  tick_count = '0;
               end else if (nxt >= irq_period) begin
                  w.irq = 1'b1;
                  tick_count = 16'(nxt % irq_period);
               end else begin
                  tick_count = 16'(nxt);
               end
            end
         endcase
         owed.push_back(w);
      endfunction

      function void check_word(logic [RSP_TDATA_W-1:0] raw);
         lcd_word_type got;
         lcd_word_type want;
         got = raw[$bits(lcd_word_type)-1:0];
         if (owed.size() == 0) begin
            faults++;
            if (faults <= 10) $display("result word %h with nothing outstanding", raw);
            return;
         end
         want = owed.pop_front();
         if (got.rd !== want.rd || got.shade !== want.shade || got.red !== want.red ||
             got.green !== want.green || got.blue !== want.blue || got.irq !== want.irq) begin
            faults++;
            if (faults <= 10)
               $display({"mismatch: expected rd=%h shade=%0d rgb=%h,%h,%h irq=%b",
                         " / got rd=%h shade=%0d rgb=%h,%h,%h irq=%b"},
                        want.rd, want.shade, want.red, want.green, want.blue, want.irq,
                        got.rd, got.shade, got.red, got.green, got.blue, got.irq);
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [1:0]             req_tuser = OP_WRITE;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_we = 1'b0;
   logic [15:0]            csr_wdata = '0;

   lcd_shadow_type shadow;
   int          sent = 0;
   int          burst_left = 0;
   int          clears_left = 8;
   bit [12:0]   hot [$];

   bitplane_lcd_controller dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) shadow.check_word(rsp_tdata);
   end

   // offers one word, in bursts that are mostly separated by idle gaps
   task automatic push(bit [1:0] op, bit [2:0] addr, bit [7:0] data, bit [7:0] x, bit [7:0] y);
      int gap;
      // each clear costs a full memory sweep, so keep them few
      if (op == OP_WRITE && addr == REG_MODE && data[7]) begin
         if (clears_left == 0) data[7] = 1'b0;
         else clears_left--;
      end
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 24);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {5'd0, y, x, data, addr};
      do @(posedge clock); while (!req_tready);
      shadow.take_command(op, addr, data, x, y);
      sent++;
   endtask

   task automatic write_reg(bit [2:0] addr, bit [7:0] data);
      push(OP_WRITE, addr, data, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
   endtask

   task automatic read_reg(bit [2:0] addr);
      push(OP_READ, addr, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
           8'($urandom_range(0, 255)));
   endtask

   task automatic fetch_pixel(bit [7:0] x, bit [7:0] y);
      push(OP_PIXEL, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), x, y);
   endtask

   task automatic tick();
      push(OP_TICK, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
           8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (shadow.owed.size() != 0) @(posedge clock);
      // a remainder run or a plane sweep may still be busy
      while (!req_tready) @(posedge clock);
   endtask

   task automatic load_period(bit [15:0] period);
      csr_we <= 1'b1;
      csr_wdata <= period;
      @(posedge clock);
      csr_we <= 1'b0;
      shadow.irq_period = period;
   endtask

   // random bytes into the same run of addresses in both planes so every shade turns up
   task automatic fill_block();
      bit [7:0]  row;
      bit [4:0]  colb;
      bit [12:0] idx;
      int        n;
      row = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(200, 223))
                                        : 8'($urandom_range(0, 199));
      colb = 5'($urandom_range(0, 31));
      n = $urandom_range(2, 12);
      write_reg(REG_PTR_HI, row);
      for (int p = 0; p < 2; p++) begin
         write_reg(REG_PTR_LO, {p[0], 2'($urandom_range(0, 3)), colb});
         idx = {row, colb};
         for (int k = 0; k < n; k++) begin
            write_reg(REG_DATA_WR, 8'($urandom_range(0, 255)));
            if (p == 0) begin
               hot.push_back(idx);
               if (hot.size() > 48) void'(hot.pop_front());
            end
            idx = idx + (shadow.step_by_row ? PTR_STEP_ROW : PTR_STEP_ONE);
         end
      end
   endtask

   task automatic read_block();
      bit [12:0] idx;
      idx = (hot.size() != 0) ? hot[$urandom_range(0, hot.size() - 1)] : 13'($urandom);
      write_reg(REG_PTR_HI, idx[12:5]);
      write_reg(REG_PTR_LO, {1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), idx[4:0]});
      repeat ($urandom_range(1, 12)) read_reg(REG_DATA_RD);
   endtask

   // mostly aim at bytes written lately, undoing the scroll
   task automatic pixel_block();
      bit [12:0] idx;
      bit [7:0]  col;
      bit [7:0]  x;
      bit [7:0]  y;
      repeat ($urandom_range(2, 16)) begin
         x = 8'($urandom_range(0, 255));
         y = 8'($urandom_range(0, 255));
         if (hot.size() != 0 && $urandom_range(0, 9) < 7) begin
            idx = hot[$urandom_range(0, hot.size() - 1)];
            col = {idx[4:0], 3'($urandom_range(0, 7))};
            if (idx[12:5] >= WINDOW_ROW_BASE) begin
               y = idx[12:5] - WINDOW_ROW_BASE;
               x = col;
            end else if (idx[12:5] < ROW_MODULO) begin
               y = 8'((int'(idx[12:5]) + 400 - int'(shadow.scroll_y)) % 200);
               x = col - shadow.scroll_x;
            end
         end
         fetch_pixel(x, y);
      end
   endtask

   task automatic mode_block();
      bit [7:0] m;
      m = 8'($urandom_range(0, 255));
      m[7] = ($urandom_range(0, 15) == 0);
      write_reg(REG_MODE, m);
      if ($urandom_range(0, 1))
         write_reg(REG_SCROLL_X,
                   ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 1))
         write_reg(REG_SCROLL_Y,
                   ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom_range(0, 255)));
   endtask

   task automatic random_traffic(int n);
      int goal;
      int pick;
      goal = sent + n;
      while (sent < goal) begin
         pick = $urandom_range(0, 99);
         if (pick < 20) fill_block();
         else if (pick < 35) read_block();
         else if (pick < 60) pixel_block();
         else if (pick < 72) repeat ($urandom_range(1, 24)) tick();
         else if (pick < 80) mode_block();
         else
            repeat ($urandom_range(1, 6))
               push(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)));
      end
   endtask

   initial begin : rsp_side
      int stretch;
      int style;
      int beat;
      bit squeezed;
      squeezed = 1'b0;
      beat = 0;
      @(posedge clock);
      forever begin
         // one long hold-off so the block backs up into its input
         if (!squeezed && sent >= HOLD_AT) begin
            squeezed = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         stretch = $urandom_range(16, 160);
         style = $urandom_range(0, 3);
         repeat (stretch) begin
            beat++;
            case (style)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(0, 1));
               2: rsp_tready <= ($urandom_range(0, 7) != 0);
               default: rsp_tready <= (beat % 7) > 2;
            endcase
            @(posedge clock);
         end
      end
   end

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < LIMIT_CYCLES) begin
         @(posedge clock);
         cycles++;
      end
      $display("tb_bitplane_lcd_controller NOT OK");
      $finish;
   end

   initial begin : stimulus
      bit [15:0] periods [7];
      shadow = new();
      periods = '{16'd0, 16'd1, 16'hFFFF, 16'd5, IRQ_PERIOD_RESET, 16'd2, 16'd0};
      periods[6] = 16'($urandom_range(6, 400));
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      load_period(16'd2);

      read_reg(REG_UNUSED);
      read_reg(REG_DATA_RD);
      write_reg(REG_UNUSED, 8'hFF);
      write_reg(REG_DATA_RD, 8'hFF);
      write_reg(REG_MODE, 8'h80);
      write_reg(REG_PTR_LO, 8'h00);
      write_reg(REG_DATA_WR, 8'hF0);
      write_reg(REG_PTR_LO, 8'h80);
      write_reg(REG_DATA_WR, 8'hCC);
      fetch_pixel(8'd0, 8'd0);
      fetch_pixel(8'd4, 8'd0);
      fetch_pixel(8'd7, 8'd0);
      write_reg(REG_MODE, 8'h40);
      write_reg(REG_PTR_HI, 8'hFF);
      write_reg(REG_PTR_LO, 8'h9F);
      // row step from the last byte wraps to the top of the plane
      write_reg(REG_DATA_WR, 8'hA5);
      read_reg(REG_DATA_RD);
      write_reg(REG_MODE, 8'h70);
      write_reg(REG_SCROLL_Y, 8'hB8);
      write_reg(REG_SCROLL_X, 8'hFE);
      fetch_pixel(8'd4, 8'd16);
      fetch_pixel(8'd255, 8'd255);
      fetch_pixel(8'd0, 8'd15);
      tick();
      tick();

      foreach (periods[i]) begin
         settle();
         load_period(periods[i]);
         random_traffic(RANDOM_ITEMS / 7);
      end

      settle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (shadow.faults == 0 && shadow.owed.size() == 0)
         $display("tb_bitplane_lcd_controller OK");
      else
         $display("tb_bitplane_lcd_controller NOT OK");
      $finish;
   end

endmodule

[bitplane_lcd_controller.f]
+incdir+design
design/blc_pkg.sv
design/blc_ram.sv
design/blc_ctrl.sv
design/blc_datapath.sv
design/bitplane_lcd_controller.sv
tb/tb_bitplane_lcd_controller.sv
